// ===== rtl/stk_pkg.sv =====
// Shared types, codes and character-class helpers for the script tokenizer.
package stk_pkg;

  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_END  = 2'd1,
    EV_ERR  = 2'd2,
    EV_DONE = 2'd3
  } ev_code_t;

  typedef enum logic [1:0] {
    K_NAME = 2'd0,
    K_NUM  = 2'd1,
    K_STR  = 2'd2,
    K_OP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EXPONENT = 3'd1,
    ERR_NUMBER   = 3'd2,
    ERR_UNTERM   = 3'd3,
    ERR_CONTROL  = 3'd4
  } err_t;

  // one result word, before the last flag is attached
  typedef struct packed {
    ev_code_t   ev;
    kind_t      kind;
    logic [7:0] data;
    logic       start;
    err_t       err;
  } stk_ev_t;

  localparam int MAX_EV = 4;
  localparam int EV_CW  = $clog2(MAX_EV + 1);
  localparam int EV_IW  = $clog2(MAX_EV);

  // all results caused by one input word
  typedef struct packed {
    logic [EV_CW-1:0]        cnt;
    stk_ev_t [MAX_EV-1:0]    ev;
  } stk_bundle_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } stk_qstat_t;

  function automatic stk_ev_t mk_ev(ev_code_t e, kind_t k, logic [7:0] d, logic s, err_t c);
    stk_ev_t r;
    r.ev    = e;
    r.kind  = k;
    r.data  = d;
    r.start = s;
    r.err   = c;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b | 8'h20) inside {["a":"z"]};
  endfunction

  function automatic logic is_prefix(logic [7:0] b);
    return b inside {"<", ">", "+", "-", "&"};
  endfunction

  function automatic logic is_suffix(logic [7:0] b);
    return b inside {"=", ">", "&", ":"};
  endfunction

  // whitespace outside strings: control bytes, space and the signed-negative range
  function automatic logic is_space(logic [7:0] b);
    return b[7] || (b <= 8'd32);
  endfunction

endpackage

// ===== rtl/stk_front.sv =====
// Lexer state machine: takes one source word and builds the bundle of results it causes.
module stk_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  output logic                push,
  output stk_pkg::stk_bundle_t bundle
);
  import stk_pkg::*;

  typedef enum logic [13:0] {
    M_IDLE    = 14'b00000000000001,
    M_NAME    = 14'b00000000000010,
    M_INT     = 14'b00000000000100,
    M_FRAC    = 14'b00000000001000,
    M_EXPS    = 14'b00000000010000,
    M_EXPSIGN = 14'b00000000100000,
    M_EXPD    = 14'b00000001000000,
    M_STR     = 14'b00000010000000,
    M_ESC     = 14'b00000100000000,
    M_UNI     = 14'b00001000000000,
    M_SLASH   = 14'b00010000000000,
    M_COMMENT = 14'b00100000000000,
    M_PREFIX  = 14'b01000000000000,
    M_ERROR   = 14'b10000000000000
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] quote_r, quote_nxt;
  logic [2:0] ecnt_r, ecnt_nxt;
  logic [7:0] eval_r, eval_nxt;
  logic       edone_r, edone_nxt;
  logic       hasb_r, hasb_nxt;

  // token start from an idle position
  logic            [1:0] si_cnt;
  stk_ev_t         [1:0] si_ev;
  mode_t                 si_mode;
  logic                  si_quote;

  logic                  eoi;
  logic                  use_si;
  logic [EV_CW-1:0]      cnt;
  stk_ev_t [MAX_EV-1:0]  evs;

  assign eoi = in_end || (in_byte == 8'd0);

  always_comb begin
    si_cnt   = 2'd0;
    si_ev    = '0;
    si_mode  = M_IDLE;
    si_quote = 1'b0;
    if (is_space(in_byte)) begin
      si_mode = M_IDLE;
    end else if (is_alpha(in_byte)) begin
      si_ev[0] = mk_ev(EV_BYTE, K_NAME, in_byte, 1'b1, ERR_NONE);
      si_cnt   = 2'd1;
      si_mode  = M_NAME;
    end else if (is_digit(in_byte)) begin
      si_ev[0] = mk_ev(EV_BYTE, K_NUM, in_byte, 1'b1, ERR_NONE);
      si_cnt   = 2'd1;
      si_mode  = M_INT;
    end else if (in_byte inside {"'", "\""}) begin
      si_quote = 1'b1;
      si_mode  = M_STR;
    end else if (in_byte == "/") begin
      si_mode = M_SLASH;
    end else if (is_prefix(in_byte)) begin
      si_ev[0] = mk_ev(EV_BYTE, K_OP, in_byte, 1'b1, ERR_NONE);
      si_cnt   = 2'd1;
      si_mode  = M_PREFIX;
    end else begin
      si_ev[0] = mk_ev(EV_BYTE, K_OP, in_byte, 1'b1, ERR_NONE);
      si_ev[1] = mk_ev(EV_END, K_OP, 8'd0, 1'b0, ERR_NONE);
      si_cnt   = 2'd2;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    ecnt_nxt  = ecnt_r;
    eval_nxt  = eval_r;
    edone_nxt = edone_r;
    hasb_nxt  = hasb_r;
    cnt       = '0;
    evs       = '0;
    use_si    = 1'b0;
    if (eoi) begin
      case (mode_r)
        M_NAME: begin
          evs[0] = mk_ev(EV_END, K_NAME, 8'd0, 1'b0, ERR_NONE);
          cnt    = EV_CW'(1);
        end
        M_INT, M_FRAC, M_EXPD: begin
          evs[0] = mk_ev(EV_END, K_NUM, 8'd0, 1'b0, ERR_NONE);
          cnt    = EV_CW'(1);
        end
        M_PREFIX: begin
          evs[0] = mk_ev(EV_END, K_OP, 8'd0, 1'b0, ERR_NONE);
          cnt    = EV_CW'(1);
        end
        M_EXPS, M_EXPSIGN: begin
          evs[0] = mk_ev(EV_ERR, K_NUM, 8'd0, 1'b0, ERR_EXPONENT);
          cnt    = EV_CW'(1);
        end
        M_STR, M_ESC, M_UNI: begin
          evs[0] = mk_ev(EV_ERR, K_STR, 8'd0, 1'b0, ERR_UNTERM);
          cnt    = EV_CW'(1);
        end
        M_SLASH: begin
          evs[0] = mk_ev(EV_BYTE, K_OP, "/", 1'b1, ERR_NONE);
          evs[1] = mk_ev(EV_END, K_OP, 8'd0, 1'b0, ERR_NONE);
          cnt    = EV_CW'(2);
        end
        default: cnt = '0;
      endcase
      evs[cnt[EV_IW-1:0]] = mk_ev(EV_DONE, K_NAME, 8'd0, 1'b0, ERR_NONE);
      cnt       = cnt + 1'b1;
      mode_nxt  = M_IDLE;
      quote_nxt = 8'd0;
      ecnt_nxt  = 3'd0;
      eval_nxt  = 8'd0;
      edone_nxt = 1'b0;
      hasb_nxt  = 1'b0;
    end else begin
      case (mode_r)
        M_NAME: begin
          if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == "_") begin
            evs[0] = mk_ev(EV_BYTE, K_NAME, in_byte, 1'b0, ERR_NONE);
            cnt    = EV_CW'(1);
          end else begin
            evs[0] = mk_ev(EV_END, K_NAME, 8'd0, 1'b0, ERR_NONE);
            cnt    = EV_CW'(1);
            use_si = 1'b1;
          end
        end
        M_INT, M_FRAC, M_EXPD: begin
          if (is_digit(in_byte)) begin
            evs[0] = mk_ev(EV_BYTE, K_NUM, in_byte, 1'b0, ERR_NONE);
            cnt    = EV_CW'(1);
          end else if (in_byte == "." && mode_r == M_INT) begin
            evs[0]   = mk_ev(EV_BYTE, K_NUM, in_byte, 1'b0, ERR_NONE);
            cnt      = EV_CW'(1);
            mode_nxt = M_FRAC;
          end else if (in_byte inside {"e", "E"} && mode_r != M_EXPD) begin
            evs[0]   = mk_ev(EV_BYTE, K_NUM, in_byte, 1'b0, ERR_NONE);
            cnt      = EV_CW'(1);
            mode_nxt = M_EXPS;
          end else if (is_alpha(in_byte)) begin
            evs[0]   = mk_ev(EV_ERR, K_NUM, 8'd0, 1'b0, ERR_NUMBER);
            cnt      = EV_CW'(1);
            mode_nxt = M_ERROR;
          end else begin
            evs[0] = mk_ev(EV_END, K_NUM, 8'd0, 1'b0, ERR_NONE);
            cnt    = EV_CW'(1);
            use_si = 1'b1;
          end
        end
        M_EXPS, M_EXPSIGN: begin
          evs[0] = mk_ev(EV_BYTE, K_NUM, in_byte, 1'b0, ERR_NONE);
          cnt    = EV_CW'(1);
          if (mode_r == M_EXPS && in_byte inside {"+", "-"}) begin
            mode_nxt = M_EXPSIGN;
          end else if (is_digit(in_byte)) begin
            mode_nxt = M_EXPD;
          end else begin
            evs[0]   = mk_ev(EV_ERR, K_NUM, 8'd0, 1'b0, ERR_EXPONENT);
            mode_nxt = M_ERROR;
          end
        end
        M_STR: begin
          if (in_byte[7] || in_byte < 8'd32) begin
            evs[0]   = mk_ev(EV_ERR, K_STR, 8'd0, 1'b0,
                             (in_byte inside {8'd10, 8'd13}) ? ERR_UNTERM : ERR_CONTROL);
            cnt      = EV_CW'(1);
            mode_nxt = M_ERROR;
          end else if (in_byte == quote_r) begin
            evs[0]   = mk_ev(EV_END, K_STR, 8'd0, 1'b0, ERR_NONE);
            cnt      = EV_CW'(1);
            mode_nxt = M_IDLE;
          end else if (in_byte == "\\") begin
            mode_nxt = M_ESC;
          end else begin
            evs[0]   = mk_ev(EV_BYTE, K_STR, in_byte, !hasb_r, ERR_NONE);
            cnt      = EV_CW'(1);
            hasb_nxt = 1'b1;
          end
        end
        M_ESC: begin
          mode_nxt = M_STR;
          if (in_byte == "u") begin
            ecnt_nxt  = 3'd0;
            eval_nxt  = 8'd0;
            edone_nxt = 1'b0;
            mode_nxt  = M_UNI;
          end else begin
            case (in_byte)
              "b":     evs[0] = mk_ev(EV_BYTE, K_STR, 8'd8, !hasb_r, ERR_NONE);
              "f":     evs[0] = mk_ev(EV_BYTE, K_STR, 8'd12, !hasb_r, ERR_NONE);
              "n":     evs[0] = mk_ev(EV_BYTE, K_STR, 8'd10, !hasb_r, ERR_NONE);
              "r":     evs[0] = mk_ev(EV_BYTE, K_STR, 8'd13, !hasb_r, ERR_NONE);
              "t":     evs[0] = mk_ev(EV_BYTE, K_STR, 8'd9, !hasb_r, ERR_NONE);
              default: evs[0] = mk_ev(EV_BYTE, K_STR, in_byte, !hasb_r, ERR_NONE);
            endcase
            cnt      = EV_CW'(1);
            hasb_nxt = 1'b1;
          end
        end
        M_UNI: begin
          ecnt_nxt = ecnt_r + 3'd1;
          if (!edone_r) begin
            if (is_digit(in_byte)) begin
              // value * 10 + digit, kept to a byte
              eval_nxt = (eval_r << 3) + (eval_r << 1) + {4'd0, in_byte[3:0]};
            end else begin
              edone_nxt = 1'b1;
            end
          end
          if (ecnt_nxt >= 3'd4) begin
            evs[0]   = mk_ev(EV_BYTE, K_STR, eval_nxt, !hasb_r, ERR_NONE);
            cnt      = EV_CW'(1);
            hasb_nxt = 1'b1;
            mode_nxt = M_STR;
          end
        end
        M_SLASH: begin
          if (in_byte == "/") begin
            mode_nxt = M_COMMENT;
          end else begin
            evs[0] = mk_ev(EV_BYTE, K_OP, "/", 1'b1, ERR_NONE);
            evs[1] = mk_ev(EV_END, K_OP, 8'd0, 1'b0, ERR_NONE);
            cnt    = EV_CW'(2);
            use_si = 1'b1;
          end
        end
        M_COMMENT: begin
          if (in_byte inside {8'd10, 8'd13}) mode_nxt = M_IDLE;
        end
        M_PREFIX: begin
          if (is_suffix(in_byte)) begin
            evs[0] = mk_ev(EV_BYTE, K_OP, in_byte, 1'b0, ERR_NONE);
            cnt    = EV_CW'(1);
          end else begin
            evs[0] = mk_ev(EV_END, K_OP, 8'd0, 1'b0, ERR_NONE);
            cnt    = EV_CW'(1);
            use_si = 1'b1;
          end
        end
        M_ERROR: mode_nxt = M_ERROR;
        default: use_si = 1'b1;
      endcase
      if (use_si) begin
        for (int i = 0; i < 2; i++) begin
          if (i < int'(si_cnt)) begin
            evs[cnt[EV_IW-1:0]] = si_ev[i];
            cnt = cnt + 1'b1;
          end
        end
        mode_nxt = si_mode;
        if (si_quote) begin
          quote_nxt = in_byte;
          hasb_nxt  = 1'b0;
        end
      end
    end
  end

  assign push       = take && (cnt != '0);
  assign bundle.cnt = cnt;
  assign bundle.ev  = evs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      quote_r <= 8'd0;
      ecnt_r  <= 3'd0;
      eval_r  <= 8'd0;
      edone_r <= 1'b0;
      hasb_r  <= 1'b0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      ecnt_r  <= ecnt_nxt;
      eval_r  <= eval_nxt;
      edone_r <= edone_nxt;
      hasb_r  <= hasb_nxt;
    end
  end

endmodule

// ===== rtl/stk_queue.sv =====
// Short bundle queue between the lexer and the output sequencer.
module stk_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  stk_pkg::stk_bundle_t push_data,
  input  logic                 pop,
  output stk_pkg::stk_bundle_t head,
  output stk_pkg::stk_qstat_t  stat
);
  import stk_pkg::*;

  stk_bundle_t     mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/stk_back.sv =====
// Output sequencer: walks the results of the head bundle one word per cycle while out_tready is high.
module stk_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stk_pkg::stk_bundle_t head,
  input  stk_pkg::stk_qstat_t  stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic [3:0]           out_tuser,
  output logic                 out_tlast
);
  import stk_pkg::*;

  logic [EV_IW-1:0] idx_r, idx_nxt;
  stk_ev_t          cur;
  logic             fire;

  assign cur        = head.ev[idx_r];
  assign out_tvalid = !stat.empty;
  assign out_tlast  = ({1'b0, idx_r} + 1'b1) == head.cnt;
  assign out_tdata  = {4'd0, cur.err, cur.start, cur.data};
  assign out_tuser  = {cur.kind, cur.ev};
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && out_tlast;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = out_tlast ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

endmodule

// ===== rtl/script_tokenizer.sv =====
// Top level of the script tokenizer: lexer front, bundle queue, output sequencer.
//
// Input stream: one source byte per word on in_tdata[7:0]; in_tlast high (or a
// zero byte) marks end of input, which flushes the pending token and reports
// stream done. Output stream: one result per word, event and token kind in
// out_tuser, byte / start flag / error code in out_tdata; out_tlast marks the
// last result caused by one input word.
// Throughput: one input word per cycle while in_tready is high. Each input
// word becomes a bundle of zero to four results in the same cycle it is
// taken; the output side drains one result per cycle while out_tready is high.
// A four-entry bundle queue sits between the two sides: in_tready drops only
// when it is full, so a stalled receiver holds the input after four bundles
// are waiting. Words that cause no result (whitespace, comments, opening
// quotes) never enter the queue.
// Reset (rst_n low, synchronous) returns the lexer to idle and empties the
// queue.
module script_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] starts_token, [11:9] error_code
  output logic [3:0]  out_tuser,  // [1:0] event_res, [3:2] token_kind
  output logic        out_tlast   // last
);
  import stk_pkg::*;

  logic        take, push, pop;
  stk_bundle_t bundle, head;
  stk_qstat_t  stat;

  assign in_tready = !stat.full;
  assign take      = in_tvalid && in_tready;

  stk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .push    (push),
    .bundle  (bundle)
  );

  stk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (bundle),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  stk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // stream done closes its bundle
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == EV_DONE) |-> (out_tlast && out_tuser[3:2] == K_NAME))
    else $error("stream done not last of its bundle");

  // only token bytes carry data
  a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != EV_BYTE) |-> (out_tdata[8:0] == 9'd0))
    else $error("non-byte event carries data");

  // error codes only on error events
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser[1:0] == EV_ERR) == (out_tdata[11:9] != ERR_NONE)))
    else $error("error code and event disagree");

  // a bundle never lands in a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && stat.full) |-> 1'b0)
    else $error("push into full queue");

endmodule
